// ===== hdl/pwmt_pkg.sv =====
package pwmt_pkg;

    localparam int NumChannels = 4;
    localparam int CountWidth  = 16;
    localparam int DutyWidth   = 7;
    localparam int ActWidth    = 2;
    localparam int ChWidth     = 2;
    localparam int CfgIdxWidth = 3;
    localparam int CfgWidth    = 16;

    // action codes
    localparam logic [ActWidth-1:0] ACT_TICK  = 2'd0;
    localparam logic [ActWidth-1:0] ACT_DUTY  = 2'd1;
    localparam logic [ActWidth-1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_PRESCALE = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_RELOAD   = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CH_EN    = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_CNT_EN   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_IRQ_EN   = 3'd4;

    localparam logic [DutyWidth-1:0] DutyFull = 7'd100;

    // duty * reload fits in 23 bits; x / 100 == (x * 10737419) >> 30 exact for x < 2^30/76
    localparam int ProdWidth  = CountWidth + DutyWidth;
    localparam int RecipWidth = 24;
    localparam int RecipShift = 30;
    localparam logic [RecipWidth-1:0] DutyRecip = 24'd10737419;

    typedef struct packed {
        logic [CountWidth-1:0]  prescale;
        logic [CountWidth-1:0]  reload;
        logic [NumChannels-1:0] ch_en;
        logic                   cnt_en;
        logic                   irq_en;
    } t_cfg;

    typedef struct packed {
        logic [ActWidth-1:0]   action;
        logic [ChWidth-1:0]    channel;
        logic [CountWidth-1:0] compare;
    } t_cmd;

endpackage

// ===== hdl/pwmt_duty_calc.sv =====
module pwmt_duty_calc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pwmt_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pwmt_pkg::ActWidth-1:0]     i_action,
    input  logic [pwmt_pkg::ChWidth-1:0]      i_channel,
    input  logic [pwmt_pkg::DutyWidth-1:0]    i_duty_percent,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pwmt_pkg::t_cmd                    o_cmd
);

    localparam int FullWidth = pwmt_pkg::ProdWidth + pwmt_pkg::RecipWidth;

    // stage 1: captured request
    logic                              r_s1_vld;
    logic [pwmt_pkg::ActWidth-1:0]     r_s1_action;
    logic [pwmt_pkg::ChWidth-1:0]      r_s1_channel;
    logic [pwmt_pkg::DutyWidth-1:0]    r_s1_duty;
    // stage 2: duty * reload
    logic                              r_s2_vld;
    logic [pwmt_pkg::ActWidth-1:0]     r_s2_action;
    logic [pwmt_pkg::ChWidth-1:0]      r_s2_channel;
    logic [pwmt_pkg::ProdWidth-1:0]    r_s2_prod;
    // stage 3: divided by hundred
    logic                              r_s3_vld;
    pwmt_pkg::t_cmd                    r_s3_cmd;

    logic                              w_s1_ready;
    logic                              w_s2_ready;
    logic                              w_s3_ready;
    logic [pwmt_pkg::DutyWidth-1:0]    w_duty;
    logic [pwmt_pkg::ProdWidth-1:0]    n_s2_prod;
    logic [FullWidth-1:0]              w_full;
    logic [pwmt_pkg::CountWidth-1:0]   n_s3_compare;

    assign w_s3_ready = !r_s3_vld || i_ready;
    assign w_s2_ready = !r_s2_vld || w_s3_ready;
    assign w_s1_ready = !r_s1_vld || w_s2_ready;
    assign o_ready    = w_s1_ready;

    assign w_duty    = (r_s1_duty > pwmt_pkg::DutyFull) ? pwmt_pkg::DutyFull : r_s1_duty;
    assign n_s2_prod = pwmt_pkg::ProdWidth'(w_duty) * pwmt_pkg::ProdWidth'(i_cfg.reload);

    assign w_full = {{pwmt_pkg::RecipWidth{1'b0}}, r_s2_prod}
                  * {{pwmt_pkg::ProdWidth{1'b0}}, pwmt_pkg::DutyRecip};
    assign n_s3_compare = w_full[pwmt_pkg::RecipShift +: pwmt_pkg::CountWidth];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_vld <= i_valid;
            end
            if (w_s2_ready) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_s3_ready) begin
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            r_s1_action  <= i_action;
            r_s1_channel <= i_channel;
            r_s1_duty    <= i_duty_percent;
        end
        if (w_s2_ready && r_s1_vld) begin
            r_s2_action  <= r_s1_action;
            r_s2_channel <= r_s1_channel;
            r_s2_prod    <= n_s2_prod;
        end
        if (w_s3_ready && r_s2_vld) begin
            r_s3_cmd.action  <= r_s2_action;
            r_s3_cmd.channel <= r_s2_channel;
            r_s3_cmd.compare <= n_s3_compare;
        end
    end

    assign o_valid = r_s3_vld;
    assign o_cmd   = r_s3_cmd;

endmodule

// ===== hdl/pwmt_core.sv =====
module pwmt_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pwmt_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pwmt_pkg::t_cmd                      i_cmd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pwmt_pkg::NumChannels-1:0]    o_pwm_level,
    output logic [pwmt_pkg::CountWidth-1:0]     o_counter_value,
    output logic                                o_update_flag,
    output logic                                o_interrupt_request
);

    logic [pwmt_pkg::CountWidth-1:0]  r_pre_cnt;
    logic [pwmt_pkg::CountWidth-1:0]  r_main_cnt;
    logic [pwmt_pkg::CountWidth-1:0]  r_cmp [pwmt_pkg::NumChannels];
    logic                             r_flag;
    logic [pwmt_pkg::CountWidth-1:0]  n_pre_cnt;
    logic [pwmt_pkg::CountWidth-1:0]  n_main_cnt;
    logic [pwmt_pkg::CountWidth-1:0]  n_cmp [pwmt_pkg::NumChannels];
    logic                             n_flag;

    // state already holds the effect of the request in this slot
    logic                             r_tok_vld;
    logic                             r_out_vld;
    logic [pwmt_pkg::NumChannels-1:0] r_out_level;
    logic [pwmt_pkg::CountWidth-1:0]  r_out_count;
    logic                             r_out_flag;
    logic                             r_out_irq;

    logic                             w_out_ready;
    logic                             w_tok_ready;
    logic                             w_accept;
    logic [pwmt_pkg::NumChannels-1:0] w_level;

    assign w_out_ready = !r_out_vld || i_ready;
    assign w_tok_ready = !r_tok_vld || w_out_ready;
    assign o_ready     = w_tok_ready;
    assign w_accept    = i_valid && w_tok_ready;

    always_comb begin
        n_pre_cnt  = r_pre_cnt;
        n_main_cnt = r_main_cnt;
        n_cmp      = r_cmp;
        n_flag     = r_flag;
        if (w_accept) begin
            case (i_cmd.action)
                pwmt_pkg::ACT_TICK: begin
                    if (i_cfg.cnt_en) begin
                        if (r_pre_cnt >= i_cfg.prescale) begin
                            n_pre_cnt = '0;
                            // a counter above a lowered reload wraps too
                            if (r_main_cnt >= i_cfg.reload) begin
                                n_main_cnt = '0;
                                n_flag     = 1'b1;
                            end else begin
                                n_main_cnt = r_main_cnt + 1'b1;
                            end
                        end else begin
                            n_pre_cnt = r_pre_cnt + 1'b1;
                        end
                    end
                end
                pwmt_pkg::ACT_DUTY: begin
                    n_cmp[i_cmd.channel] = i_cmd.compare;
                end
                pwmt_pkg::ACT_CLEAR: begin
                    n_flag = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < pwmt_pkg::NumChannels; c++) begin
            w_level[c] = i_cfg.ch_en[c] && (r_main_cnt < r_cmp[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cnt  <= '0;
            r_main_cnt <= '0;
            r_flag     <= 1'b0;
            r_tok_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int c = 0; c < pwmt_pkg::NumChannels; c++) begin
                r_cmp[c] <= '0;
            end
        end else begin
            r_pre_cnt  <= n_pre_cnt;
            r_main_cnt <= n_main_cnt;
            r_flag     <= n_flag;
            r_cmp      <= n_cmp;
            if (w_tok_ready) begin
                r_tok_vld <= i_valid;
            end
            if (w_out_ready) begin
                r_out_vld <= r_tok_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_tok_vld) begin
            r_out_level <= w_level;
            r_out_count <= r_main_cnt;
            r_out_flag  <= r_flag;
            r_out_irq   <= r_flag && i_cfg.irq_en;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_pwm_level         = r_out_level;
    assign o_counter_value     = r_out_count;
    assign o_update_flag       = r_out_flag;
    assign o_interrupt_request = r_out_irq;

endmodule

// ===== hdl/pwm_timer_four_channel_top.sv =====
// channel   direction  handshake             payload
// request   in         i_valid / o_ready     i_action, i_channel, i_duty_percent
// status    out        o_valid / i_ready     o_pwm_level, o_counter_value,
//                                            o_update_flag, o_interrupt_request
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// one request per cycle sustained while the status output is not stalled; a request passes
// the capture register, the duty multiply, the divide-by-hundred multiply, the state update
// and the status register before status is valid.
// reset (i_rst_n low, synchronous) clears counters, compares, flag and all stage valids.
// a stalled status output backs up the stages one by one; requests keep flowing into
// empty stages until the pipe is full.
module pwm_timer_four_channel_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pwmt_pkg::CfgIdxWidth-1:0]      i_cfg_idx,
    input  logic [pwmt_pkg::CfgWidth-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [pwmt_pkg::ActWidth-1:0]         i_action,
    input  logic [pwmt_pkg::ChWidth-1:0]          i_channel,
    input  logic [pwmt_pkg::DutyWidth-1:0]        i_duty_percent,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [pwmt_pkg::NumChannels-1:0]      o_pwm_level,
    output logic [pwmt_pkg::CountWidth-1:0]       o_counter_value,
    output logic                                  o_update_flag,
    output logic                                  o_interrupt_request
);

    pwmt_pkg::t_cfg r_cfg;
    pwmt_pkg::t_cmd w_cmd;
    logic           w_cmd_vld;
    logic           w_cmd_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale <= '0;
            r_cfg.reload   <= '1;
            r_cfg.ch_en    <= '0;
            r_cfg.cnt_en   <= 1'b0;
            r_cfg.irq_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwmt_pkg::CFG_PRESCALE: r_cfg.prescale <= i_cfg_data;
                pwmt_pkg::CFG_RELOAD:   r_cfg.reload   <= i_cfg_data;
                pwmt_pkg::CFG_CH_EN:    r_cfg.ch_en    <= i_cfg_data[pwmt_pkg::NumChannels-1:0];
                pwmt_pkg::CFG_CNT_EN:   r_cfg.cnt_en   <= i_cfg_data[0];
                pwmt_pkg::CFG_IRQ_EN:   r_cfg.irq_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pwmt_duty_calc u_duty_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_channel      (i_channel),
        .i_duty_percent (i_duty_percent),
        .o_valid        (w_cmd_vld),
        .i_ready        (w_cmd_rdy),
        .o_cmd          (w_cmd)
    );

    pwmt_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_valid             (w_cmd_vld),
        .o_ready             (w_cmd_rdy),
        .i_cmd               (w_cmd),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_pwm_level         (o_pwm_level),
        .o_counter_value     (o_counter_value),
        .o_update_flag       (o_update_flag),
        .o_interrupt_request (o_interrupt_request)
    );

endmodule
